### hw/rtl/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg: shared types and codes for the ordered list store
// Request codes, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package ols_pkg;

  typedef enum logic [2:0] {
    OP_APPEND       = 3'd0,
    OP_INSERT       = 3'd1,
    OP_REMOVE_AT    = 3'd2,
    OP_REMOVE_VALUE = 3'd3,
    OP_CHANGE_AT    = 3'd4,
    OP_CHANGE_VALUE = 3'd5,
    OP_GET          = 3'd6,
    OP_FIND         = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

### hw/rtl/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered_list_store: ordered sequence of data words with positional edits
// Append, insert, remove, overwrite, read and search over a store with one read and one write port.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the in_ channel (valid/stall); one result transaction
//   leaves on the out_ channel per request. in_stall is high while a request
//   is being worked on, so one request is in the block at a time.
//   Append, change_at and rejected requests finish without a scan; insert
//   and remove_at move the entries after the position, get reads one entry,
//   and remove_value, change_value and find scan the whole list, a find
//   stopping at its first hit.
//   The block is built around the single entry memory: one read and one write per
//   cycle, with the read data registered, streamed under a small sequencer.
//   A new request is taken in the cycle after its predecessor's result has
//   been loaded into the output register, even while that result stalls.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; entry contents are not cleared and are never read before written.
//   While out_stall is high the result holds steady and the block finishes
//   the current request but does not overwrite the waiting transaction.
// ----------------------------------------------------------------------------
module ordered_list_store
  import ols_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int DATA_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic signed [5:0] in_position,
  input  logic [31:0]       in_value,
  input  logic [31:0]       in_new_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [31:0]       out_read_value,
  output logic [3:0]        out_found_index,
  output logic [4:0]        out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > 6) ? CW : 6) + 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // entry store: one write, one registered read per cycle
  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [DATA_BITS-1:0] rdata_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DATA_BITS-1:0] wr_data;

  state_t state_r, state_nxt;

  // registered request
  op_t                  op_r;
  logic signed [5:0]    pos_r;
  logic [DATA_BITS-1:0] val_r, nval_r;

  logic [CW-1:0]        count_r, count_nxt;

  // scan engine
  logic                 iss_r, iss_nxt;
  logic [AW-1:0]        ip_r, ip_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic                 rv_r;
  logic [AW-1:0]        ra_r;
  logic [CW-1:0]        wp_r, wp_nxt;
  logic                 hit_r, hit_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;

  // result being assembled
  status_t              res_st_r, res_st_nxt;
  logic [DATA_BITS-1:0] res_rd_r, res_rd_nxt;
  logic [AW-1:0]        res_fidx_r, res_fidx_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r;
  logic [31:0]          out_read_value_r;
  logic [3:0]           out_found_index_r;
  logic [4:0]           out_entry_count_r;
  logic                 out_load;

  logic                 in_accept;
  logic                 scan_done;
  logic [63:0]          in_val_w, in_nval_w;

  // position resolution
  logic signed [SW-1:0] pos_s, n_s, ex_r, ins_r;
  logic                 ex_ok, ins_ok, full;
  logic [AW-1:0]        ex_idx, ins_idx;
  logic                 eq;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign scan_done = !iss_r && !rv_r;
  assign full      = (count_r >= DEPTH_C);
  assign eq        = (rdata_r == val_r);

  // mask the incoming words to the stored width
  assign in_val_w  = {32'd0, in_value};
  assign in_nval_w = {32'd0, in_new_value};

  assign pos_s   = SW'(pos_r);
  assign n_s     = $signed({{(SW-CW){1'b0}}, count_r});
  assign ex_r    = (pos_s < 0) ? pos_s + n_s : pos_s;
  assign ex_ok   = (ex_r >= 0) && (ex_r < n_s);
  assign ins_r   = (pos_s < 0) ? pos_s + n_s + SW'(1) : pos_s;
  assign ins_ok  = (pos_s <= n_s) && (pos_s >= -(n_s + SW'(1)));
  assign ex_idx  = ex_r[AW-1:0];
  assign ins_idx = ins_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        case (op_r)
          OP_APPEND, OP_CHANGE_AT: state_nxt = S_DONE;
          OP_INSERT: state_nxt = (!ins_ok || full) ? S_DONE : S_SCAN;
          OP_REMOVE_AT, OP_GET: state_nxt = ex_ok ? S_SCAN : S_DONE;
          default: state_nxt = S_SCAN;
        endcase
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    ip_nxt        = ip_r;
    last_nxt      = last_r;
    wp_nxt        = wp_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    res_st_nxt    = res_st_r;
    res_rd_nxt    = res_rd_r;
    res_fidx_nxt  = res_fidx_r;
    rd_en         = 1'b0;
    rd_addr       = ip_r;
    wr_en         = 1'b0;
    wr_addr       = ra_r;
    wr_data       = rdata_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_CHECK: begin
        res_st_nxt   = ST_OK;
        res_rd_nxt   = '0;
        res_fidx_nxt = '0;
        hit_nxt      = 1'b0;
        wp_nxt       = '0;
        iss_nxt      = 1'b0;
        ip_nxt       = '0;
        last_nxt     = AW'(count_r - CW'(1));
        case (op_r)
          OP_APPEND: begin
            if (full) begin
              res_st_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[AW-1:0];
              wr_data   = val_r;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_INSERT: begin
            if (!ins_ok) begin
              res_st_nxt = ST_BADPOS;
            end else if (full) begin
              res_st_nxt = ST_FULL;
            end else begin
              // shift the tail down one place, last entry first
              idx_nxt  = ins_idx;
              iss_nxt  = (count_r[AW-1:0] != ins_idx);
              ip_nxt   = AW'(count_r - CW'(1));
              last_nxt = ins_idx;
            end
          end
          OP_REMOVE_AT: begin
            if (!ex_ok) begin
              res_st_nxt = ST_BADPOS;
            end else begin
              idx_nxt = ex_idx;
              iss_nxt = ({1'b0, ex_idx} + (AW+1)'(1)) < (AW+1)'(count_r);
              ip_nxt  = ex_idx + AW'(1);
            end
          end
          OP_CHANGE_AT: begin
            if (!ex_ok) begin
              res_st_nxt = ST_BADPOS;
            end else begin
              wr_en   = 1'b1;
              wr_addr = ex_idx;
              wr_data = val_r;
            end
          end
          OP_GET: begin
            if (!ex_ok) begin
              res_st_nxt = ST_BADPOS;
            end else begin
              iss_nxt  = 1'b1;
              ip_nxt   = ex_idx;
              last_nxt = ex_idx;
            end
          end
          default: begin
            // whole-list scans: remove_value, change_value, find
            iss_nxt = (count_r != '0);
          end
        endcase
      end

      S_SCAN: begin
        // issue side: one read a cycle until the last address, or until a find hits
        if (iss_r) begin
          rd_en = 1'b1;
          if (ip_r == last_r) begin
            iss_nxt = 1'b0;
          end else if (op_r == OP_INSERT) begin
            ip_nxt = ip_r - AW'(1);
          end else begin
            ip_nxt = ip_r + AW'(1);
          end
        end
        // return side: act on the word read last cycle
        if (rv_r) begin
          case (op_r)
            OP_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = ra_r + AW'(1);
            end
            OP_REMOVE_AT: begin
              wr_en   = 1'b1;
              wr_addr = ra_r - AW'(1);
            end
            OP_REMOVE_VALUE: begin
              if (eq) begin
                hit_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = wp_r[AW-1:0];
                wp_nxt  = wp_r + CW'(1);
              end
            end
            OP_CHANGE_VALUE: begin
              if (eq) begin
                wr_en   = 1'b1;
                wr_data = nval_r;
                hit_nxt = 1'b1;
              end
            end
            OP_FIND: begin
              if (eq && !hit_r) begin
                hit_nxt      = 1'b1;
                res_fidx_nxt = ra_r;
                iss_nxt      = 1'b0;
              end
            end
            OP_GET: begin
              res_rd_nxt = rdata_r;
            end
            default: begin
            end
          endcase
        end
        // wrap up once the stream has drained
        if (scan_done) begin
          case (op_r)
            OP_INSERT: begin
              wr_en     = 1'b1;
              wr_addr   = idx_r;
              wr_data   = val_r;
              count_nxt = count_r + CW'(1);
            end
            OP_REMOVE_AT: begin
              count_nxt = count_r - CW'(1);
            end
            OP_REMOVE_VALUE: begin
              count_nxt = wp_r;
              if (!hit_r) res_st_nxt = ST_NOTFOUND;
            end
            OP_CHANGE_VALUE, OP_FIND: begin
              if (!hit_r) res_st_nxt = ST_NOTFOUND;
            end
            default: begin
            end
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_r       <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      rv_r        <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= op_t'(in_req_type);
      pos_r  <= in_position;
      val_r  <= in_val_w[DATA_BITS-1:0];
      nval_r <= in_nval_w[DATA_BITS-1:0];
    end
    ip_r       <= ip_nxt;
    last_r     <= last_nxt;
    ra_r       <= ip_r;
    wp_r       <= wp_nxt;
    hit_r      <= hit_nxt;
    idx_r      <= idx_nxt;
    res_st_r   <= res_st_nxt;
    res_rd_r   <= res_rd_nxt;
    res_fidx_r <= res_fidx_nxt;
    if (out_load) begin
      out_status_r      <= res_st_r;
      out_read_value_r  <= 32'({32'd0, res_rd_r});
      out_found_index_r <= 4'({4'd0, res_fidx_r});
      out_entry_count_r <= 5'({5'd0, count_r});
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_found_index = out_found_index_r;
  assign out_entry_count = out_entry_count_r;

endmodule

### sim/ordered_list_store_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_store_tb: self-checking bench for the ordered list store
// A queue-fed driver sends list requests on the in_ channel and a monitor
// checks every result transaction against a shadow copy of the list kept in
// the bench. A directed opening covers empty and full stores and the range
// limits of positions. Four random phases follow, with and without idle
// cycles on either side, and the bench waits for every result between phases.
// ----------------------------------------------------------------------------
module ordered_list_store_tb
  import ols_pkg::*;
;

  localparam int LIST_DEPTH = 16;
  localparam int CLK_PERIOD = 10;
  localparam int PHASE_ITEMS = 370;
  localparam int TAIL_CYCLES = 40;
  // Allow several times the slowest correct run.
  localparam longint RUN_LIMIT = 64'd6_000_000;

  typedef struct packed {
    op_t               op;
    logic signed [5:0] pos;
    logic [31:0]       val;
    logic [31:0]       nval;
  } list_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] rd;
    logic [3:0]  idx;
    logic [4:0]  cnt;
  } list_rsp_t;

  typedef struct {
    logic [31:0] word [LIST_DEPTH];
    int          cnt;
  } list_image_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_req_type = '0;
  logic signed [5:0] in_position = '0;
  logic [31:0]       in_value = '0;
  logic [31:0]       in_new_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [31:0]       out_read_value;
  logic [3:0]        out_found_index;
  logic [4:0]        out_entry_count;

  list_req_t   pending_q[$];   // requests waiting to be offered
  list_rsp_t   expected_q[$];  // predicted results, oldest first
  list_image_t gen_img;        // list as the generator sees it
  list_image_t model_img;      // list as seen by accepted requests
  list_req_t   offered_req;    // request currently on the in_ channel
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;

  ordered_list_store i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_value        (in_value),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count)
  );

  // Apply one request to a list image and return the result it yields.
  function automatic list_rsp_t apply_request(ref list_image_t img, input list_req_t rq);
    list_rsp_t rsp;
    int        p;
    int        n;
    int        k;
    int        j;
    bit        hit;
    rsp = '{status: ST_OK, rd: '0, idx: '0, cnt: '0};
    n = img.cnt;
    p = int'($signed(rq.pos));
    case (rq.op)
      OP_APPEND: begin
        if (n >= LIST_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          img.word[n] = rq.val;
          img.cnt = n + 1;
        end
      end
      OP_INSERT: begin
        // Check the position first; a full store only matters if it is legal.
        if (p > n || p < -(n + 1)) begin
          rsp.status = ST_BADPOS;
        end else if (n >= LIST_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          if (p < 0) p = p + n + 1;
          for (k = n; k > p; k--) img.word[k] = img.word[k - 1];
          img.word[p] = rq.val;
          img.cnt = n + 1;
        end
      end
      OP_REMOVE_VALUE: begin
        j = 0;
        for (k = 0; k < n; k++) begin
          if (img.word[k] != rq.val) begin
            img.word[j] = img.word[k];
            j++;
          end
        end
        if (j == n) rsp.status = ST_NOTFOUND;
        img.cnt = j;
      end
      OP_CHANGE_VALUE: begin
        hit = 1'b0;
        for (k = 0; k < n; k++) begin
          if (img.word[k] == rq.val) begin
            img.word[k] = rq.nval;
            hit = 1'b1;
          end
        end
        if (!hit) rsp.status = ST_NOTFOUND;
      end
      OP_FIND: begin
        rsp.status = ST_NOTFOUND;
        for (k = 0; k < n && rsp.status != ST_OK; k++) begin
          if (img.word[k] == rq.val) begin
            rsp.idx = k[3:0];
            rsp.status = ST_OK;
          end
        end
      end
      default: begin
        // Positional edits and reads address an entry already in use.
        if (p < 0) p = p + n;
        if (p < 0 || p >= n) begin
          rsp.status = ST_BADPOS;
        end else begin
          case (rq.op)
            OP_REMOVE_AT: begin
              for (k = p; k + 1 < n; k++) img.word[k] = img.word[k + 1];
              img.cnt = n - 1;
            end
            OP_CHANGE_AT: img.word[p] = rq.val;
            default:      rsp.rd = img.word[p];
          endcase
        end
      end
    endcase
    rsp.cnt = img.cnt[4:0];
    return rsp;
  endfunction

  // Queue a request and advance the generator's view of the list.
  task automatic push_req(input op_t op, input int pos, input logic [31:0] val,
                          input logic [31:0] nval);
    list_req_t rq;
    rq.op = op;
    rq.pos = pos[5:0];
    rq.val = val;
    rq.nval = nval;
    void'(apply_request(gen_img, rq));
    pending_q.push_back(rq);
  endtask

  // Queue a run of random requests, swinging the list between empty and
  // full so that both ends are reached often.
  task automatic push_random(input int n_items);
    int  grow;
    int  roll;
    int  n;
    int  pos;
    op_t op;
    logic [31:0] val;
    logic [31:0] nval;
    grow = 1;
    repeat (n_items) begin
      n = gen_img.cnt;
      if (n == LIST_DEPTH) grow = 0;
      else if (n == 0) grow = 1;
      else if ($urandom_range(0, 29) == 0) grow = !grow;
      roll = $urandom_range(0, 99);
      if (grow) begin
        if (roll < 35) op = OP_APPEND;
        else if (roll < 60) op = OP_INSERT;
        else op = op_t'($urandom_range(2, 7));
      end else begin
        if (roll < 30) op = OP_REMOVE_AT;
        else if (roll < 45) op = OP_REMOVE_VALUE;
        else op = op_t'($urandom_range(0, 7));
      end
      // Mostly legal positions; the rest spans -17 to 16.
      if ($urandom_range(0, 99) < 15) begin
        pos = int'($urandom_range(0, 33)) - 17;
      end else if (op == OP_INSERT) begin
        pos = int'($urandom_range(0, 2 * n + 1)) - (n + 1);
      end else if (n > 0) begin
        pos = int'($urandom_range(0, 2 * n - 1)) - n;
      end else begin
        pos = 0;
      end
      // Favour words already in the list so that value searches hit.
      roll = $urandom_range(0, 99);
      if (roll < 40 && n > 0) val = gen_img.word[$urandom_range(0, n - 1)];
      else if (roll < 70) val = $urandom_range(0, 7);
      else if (roll < 90) val = $urandom;
      else val = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      nval = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom;
      push_req(op, pos, val, nval);
    end
  endtask

  // Hold the main sequence until every offered transaction has its result.
  task automatic drain_list;
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Driver: offer the next pending request, hold it until accepted, and
  // predict its result on the accepting edge.
  always @(posedge clk) begin : drive_requests
    bit        took;
    list_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        expected_q.push_back(apply_request(model_img, offered_req));
      end
      if (!in_valid || took) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          offered_req = nxt;
          in_valid <= 1'b1;
          in_req_type <= nxt.op;
          in_position <= nxt.pos;
          in_value <= nxt.val;
          in_new_value <= nxt.nval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and compare each accepted result field by field.
  always @(posedge clk) begin : check_results
    list_rsp_t exp_rsp;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d count %0d",
                   $time, out_status, out_entry_count);
          mismatch_count++;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (out_status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status, out_status);
            mismatch_count++;
          end
          if (out_read_value !== exp_rsp.rd) begin
            $display("%0t: read_value expected %h actual %h", $time, exp_rsp.rd,
                     out_read_value);
            mismatch_count++;
          end
          if (out_found_index !== exp_rsp.idx) begin
            $display("%0t: found_index expected %0d actual %0d", $time, exp_rsp.idx,
                     out_found_index);
            mismatch_count++;
          end
          if (out_entry_count !== exp_rsp.cnt) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, exp_rsp.cnt,
                     out_entry_count);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Main sequence: every change to the pending queue and the idle rates is
  // made on the falling edge, clear of the sampling edge.
  initial begin : run_sequence
    int k;
    gen_img.cnt = 0;
    model_img.cnt = 0;
    for (k = 0; k < LIST_DEPTH; k++) begin
      gen_img.word[k] = '0;
      model_img.word[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty store: every positional request is out of range.
    push_req(OP_GET, 0, 32'h0, 32'h0);
    push_req(OP_REMOVE_AT, -1, 32'h0, 32'h0);
    push_req(OP_INSERT, 1, 32'h1, 32'h0);
    push_req(OP_FIND, 0, 32'h0, 32'h0);
    push_req(OP_REMOVE_VALUE, 0, 32'h0, 32'h0);
    // Grow to full through both ends, with extreme words.
    push_req(OP_INSERT, -1, 32'h0, 32'h0);
    push_req(OP_APPEND, 0, 32'hFFFF_FFFF, 32'h0);
    push_req(OP_INSERT, 0, 32'h5, 32'h0);
    push_req(OP_INSERT, -4, 32'h7, 32'h0);
    push_req(OP_INSERT, 4, 32'h5, 32'h0);
    for (k = 0; k < 11; k++) begin
      push_req(OP_APPEND, 0, (k % 3 == 0) ? 32'h5 : k, 32'h0);
    end
    // Full store: append and a legal insert are refused.
    push_req(OP_APPEND, 0, 32'h1, 32'h0);
    push_req(OP_INSERT, 16, 32'h1, 32'h0);
    // A position equal to the count, one below the negative limit, and the limit.
    push_req(OP_GET, 16, 32'h0, 32'h0);
    push_req(OP_GET, -17, 32'h0, 32'h0);
    push_req(OP_GET, -16, 32'h0, 32'h0);
    push_req(OP_CHANGE_AT, -1, 32'hA5A5_A5A5, 32'h0);
    // Several matches of one word: replace, find, then remove them all.
    push_req(OP_CHANGE_VALUE, 0, 32'h5, 32'h1234_5678);
    push_req(OP_FIND, 0, 32'h1234_5678, 32'h0);
    push_req(OP_REMOVE_VALUE, 0, 32'h1234_5678, 32'h0);
    push_req(OP_CHANGE_VALUE, 0, 32'h99, 32'h1);
    push_req(OP_REMOVE_AT, 0, 32'h0, 32'h0);
    drain_list();

    // Random phases; drain in between so the sender waits on the results.
    push_random(PHASE_ITEMS);
    drain_list();
    send_idle_pct = 53;
    push_random(PHASE_ITEMS);
    drain_list();
    send_idle_pct = 0;
    recv_stall_pct = 53;
    push_random(PHASE_ITEMS);
    drain_list();
    send_idle_pct = 33;
    recv_stall_pct = 33;
    push_random(PHASE_ITEMS);
    drain_list();

    // Leave time for any stray result to show up.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

### ordered_list_store.f
hw/rtl/ols_pkg.sv
hw/rtl/ordered_list_store.sv
sim/ordered_list_store_tb.sv
